// ===== src/sws_pkg.sv =====
// Shared types, widths and constants of the sliding window statistics block.
package sws_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int SAMPLE_W      = 16;
    localparam int VAR_W         = 40;
    localparam int SLOPE_W       = 25;

    // Accumulator widths sized for the largest supported window (64).
    localparam int SUM_W  = 22;
    localparam int SX_W   = 12;
    localparam int SXX_W  = 17;
    localparam int SXY_W  = 28;
    localparam int PROD_W = 34;
    localparam int DEN_W  = 24;
    localparam int SQ_W   = 39;

    // Shared divider widths.
    localparam int DIVN_W = 48;
    localparam int DIVD_W = 24;

    localparam logic [VAR_W-1:0] VAR_FALLBACK = VAR_W'(256000);
    localparam int MIN_VAR_N   = 3;
    localparam int MIN_SLOPE_N = 2;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

endpackage

// ===== src/sliding_window_sample_statistics.sv =====
// Top level of the sliding window sample statistics block.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_kind, s_sample
//   m_        out        m_valid / m_ready  m_count, m_full_res, m_newest, m_mean,
//                                           m_variance_q8, m_slope_q8
//
// A store request with n samples held afterwards (n of three or more) makes
// two walks over the window RAM, one read per cycle, and three passes
// through the shared 48-step divider (mean, variance and slope). With one
// sample only the mean divide runs; with two the variance pass is skipped.
// A clear request goes straight to the result. Every request passes through
// the front queue before it reaches the back end.
// Reset (aresetn low, synchronous) empties the window and the request queue.
// The front queue holds two requests and keeps accepting until full while a
// result waits on m_ready; the back end holds its result until taken.
module sliding_window_sample_statistics #(
    parameter int WINDOW_DEPTH = sws_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [sws_pkg::SAMPLE_W-1:0]        s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]   m_count,
    output logic                                m_full_res,
    output logic [sws_pkg::SAMPLE_W-1:0]        m_newest,
    output logic [sws_pkg::SAMPLE_W-1:0]        m_mean,
    output logic [sws_pkg::VAR_W-1:0]           m_variance_q8,
    output logic signed [sws_pkg::SLOPE_W-1:0]  m_slope_q8
);

    // decoded requests handed from front to back
    sws_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_ready;

    sws_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_sample (s_sample),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    sws_back #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_count      (m_count),
        .m_full_res   (m_full_res),
        .m_newest     (m_newest),
        .m_mean       (m_mean),
        .m_variance_q8(m_variance_q8),
        .m_slope_q8   (m_slope_q8)
    );

endmodule

// ===== src/sws_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sws_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sws_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sws_pkg::DIVN_W-1:0] dividend,
    input  logic [sws_pkg::DIVD_W-1:0] divisor,
    output logic                       done,
    output logic [sws_pkg::DIVN_W-1:0] quotient
);

    localparam int N  = sws_pkg::DIVN_W;
    localparam int D  = sws_pkg::DIVD_W;
    localparam int SW = $clog2(N + 1);

    logic [N-1:0]  q_reg, q_next;
    logic [D-1:0]  r_reg, r_next;
    logic [D-1:0]  d_reg, d_next;
    logic [SW-1:0] step_reg, step_next;
    logic          done_reg, done_next;
    logic [D:0]    trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[N-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            step_next = SW'(N);
        end else if (step_reg != '0) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = D'(trial - {1'b0, d_reg});
                q_next = {q_reg[N-2:0], 1'b1};
            end else begin
                r_next = trial[D-1:0];
                q_next = {q_reg[N-2:0], 1'b0};
            end
            step_next = step_reg - SW'(1);
            done_next = (step_reg == SW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/sws_front.sv =====
// Front end: accept requests, classify them and queue them for the back end.
module sws_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [sws_pkg::SAMPLE_W-1:0] s_sample,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output sws_pkg::cmd_t                cmd
);

    sws_pkg::cmd_t q0_reg, q0_next;
    sws_pkg::cmd_t q1_reg, q1_next;
    logic [1:0]    fill_reg, fill_next;
    sws_pkg::cmd_t incoming;
    logic          push, pop;

    always_comb begin
        incoming.op     = s_kind ? sws_pkg::OP_CLEAR : sws_pkg::OP_STORE;
        incoming.sample = s_sample;
        push      = s_valid && s_ready;
        pop       = cmd_valid && cmd_ready;
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        fill_next = fill_reg;
        // advance the head, then append behind whatever remains
        if (pop) begin
            q0_next = q1_reg;
        end
        if (push) begin
            if ((fill_reg == 2'd0) || ((fill_reg == 2'd1) && pop)) begin
                q0_next = incoming;
            end else begin
                q1_next = incoming;
            end
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q0_reg;

endmodule

// ===== src/sws_back.sv =====
// Back end: update the window, walk it and compute the statistics.
module sws_back #(
    parameter int WINDOW_DEPTH = sws_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  sws_pkg::cmd_t                        cmd,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]    m_count,
    output logic                                 m_full_res,
    output logic [sws_pkg::SAMPLE_W-1:0]         m_newest,
    output logic [sws_pkg::SAMPLE_W-1:0]         m_mean,
    output logic [sws_pkg::VAR_W-1:0]            m_variance_q8,
    output logic signed [sws_pkg::SLOPE_W-1:0]   m_slope_q8
);

    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int PW  = $clog2(WINDOW_DEPTH);
    localparam int YW  = sws_pkg::SAMPLE_W;
    localparam int NW  = sws_pkg::DIVN_W;
    localparam int DW  = sws_pkg::DIVD_W;
    localparam int SUM = sws_pkg::SUM_W;
    localparam int SXW = sws_pkg::SX_W;
    localparam int SQW = sws_pkg::SXX_W;
    localparam int XYW = sws_pkg::SXY_W;
    localparam int PRW = sws_pkg::PROD_W;
    localparam int DNW = sws_pkg::DEN_W;
    localparam int VQW = sws_pkg::SQ_W;
    localparam int SLW = sws_pkg::SLOPE_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WALK1, ST_MDIV, ST_WALK2, ST_VDIV,
        ST_SPROD, ST_SDIFF, ST_SDIV, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  start_reg, start_next;
    logic [PW-1:0]  addr_reg, addr_next;
    logic [CW-1:0]  issue_reg, issue_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           rd_vld_reg, rd_vld_next;
    logic           sq_vld_reg, sq_vld_next;
    logic           go_reg, go_next;

    logic [SUM-1:0] sum_reg, sum_next;
    logic [SXW-1:0] sx_reg, sx_next;
    logic [SQW-1:0] sxx_reg, sxx_next;
    logic [XYW-1:0] sxy_reg, sxy_next;
    logic [2*YW-1:0] prod_reg, prod_next;
    logic [VQW-1:0] sq_reg, sq_next;
    logic [PRW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [DNW-1:0] p3_reg, p3_next, p4_reg, p4_next;
    logic           neg_reg, neg_next;
    logic [NW-1:0]  dvd_reg, dvd_next;
    logic [DW-1:0]  dvs_reg, dvs_next;
    logic [YW-1:0]  newest_reg, newest_next;
    logic [YW-1:0]  mean_reg, mean_next;
    logic [sws_pkg::VAR_W-1:0] var_reg, var_next;
    logic [SLW-1:0] slope_reg, slope_next;

    logic           ram_we;
    logic [YW-1:0]  ram_rdata;
    logic           div_done;
    logic [NW-1:0]  div_quot;

    logic [CW-1:0]  kp1;
    logic [CW-1:0]  cnt_new;
    logic [PW-1:0]  wp_new;
    logic [PW+1:0]  start_tmp;
    logic [YW-1:0]  diff;
    logic [VQW-1:0] sq_fin;
    logic signed [PRW:0] num;
    logic [PRW-1:0] mag;
    logic [DNW-1:0] den;
    logic [NW-1:0]  neg_quot;

    sws_ram #(
        .WIDTH(YW),
        .DEPTH(WINDOW_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(cmd.sample),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    sws_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .dividend(dvd_reg),
        .divisor (dvs_reg),
        .done    (div_done),
        .quotient(div_quot)
    );

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        wp_next     = wp_reg;
        start_next  = start_reg;
        addr_next   = addr_reg;
        issue_next  = issue_reg;
        k_next      = k_reg;
        rd_vld_next = 1'b0;
        sq_vld_next = 1'b0;
        go_next     = 1'b0;
        sum_next    = sum_reg;
        sx_next     = sx_reg;
        sxx_next    = sxx_reg;
        sxy_next    = sxy_reg;
        prod_next   = prod_reg;
        sq_next     = sq_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        p3_next     = p3_reg;
        p4_next     = p4_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        newest_next = newest_reg;
        mean_next   = mean_reg;
        var_next    = var_reg;
        slope_next  = slope_reg;
        cmd_ready   = 1'b0;
        ram_we      = 1'b0;

        kp1     = k_reg + CW'(1);
        wp_new  = (wp_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        cnt_new = (cnt_reg == CW'(WINDOW_DEPTH)) ? cnt_reg : cnt_reg + CW'(1);
        start_tmp = (PW+2)'(wp_new) + (PW+2)'(WINDOW_DEPTH) - (PW+2)'(cnt_new);
        if (start_tmp >= (PW+2)'(WINDOW_DEPTH)) begin
            start_tmp = start_tmp - (PW+2)'(WINDOW_DEPTH);
        end
        diff   = (ram_rdata >= mean_reg) ? ram_rdata - mean_reg : mean_reg - ram_rdata;
        sq_fin = sq_reg + VQW'(prod_reg);
        num    = $signed({1'b0, p1_reg}) - $signed({1'b0, p2_reg});
        mag    = num[PRW] ? PRW'(-num) : num[PRW-1:0];
        den    = p3_reg - p4_reg;
        neg_quot = -div_quot;

        // read issue shared by both window walks
        if ((state_reg == ST_WALK1) || (state_reg == ST_WALK2)) begin
            if (issue_reg < cnt_reg) begin
                rd_vld_next = 1'b1;
                issue_next  = issue_reg + CW'(1);
                addr_next   = (addr_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : addr_reg + PW'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    mean_next  = '0;
                    var_next   = sws_pkg::VAR_FALLBACK;
                    slope_next = '0;
                    if (cmd.op == sws_pkg::OP_CLEAR) begin
                        cnt_next    = '0;
                        wp_next     = '0;
                        newest_next = '0;
                        state_next  = ST_OUT;
                    end else begin
                        ram_we      = 1'b1;
                        cnt_next    = cnt_new;
                        wp_next     = wp_new;
                        newest_next = cmd.sample;
                        start_next  = start_tmp[PW-1:0];
                        addr_next   = start_tmp[PW-1:0];
                        issue_next  = '0;
                        k_next      = '0;
                        sum_next    = '0;
                        sx_next     = '0;
                        sxx_next    = '0;
                        sxy_next    = '0;
                        state_next  = ST_WALK1;
                    end
                end
            end
            ST_WALK1: begin
                if (rd_vld_reg) begin
                    sum_next = sum_reg + SUM'(ram_rdata);
                    sx_next  = sx_reg + SXW'(kp1);
                    sxx_next = sxx_reg + SQW'(SQW'(kp1) * SQW'(kp1));
                    sxy_next = sxy_reg + XYW'(XYW'(kp1) * XYW'(ram_rdata));
                    k_next   = kp1;
                    if (kp1 == cnt_reg) begin
                        dvd_next   = NW'(sum_next) + NW'(cnt_reg >> 1);
                        dvs_next   = DW'(cnt_reg);
                        go_next    = 1'b1;
                        state_next = ST_MDIV;
                    end
                end
            end
            ST_MDIV: begin
                if (div_done) begin
                    mean_next = div_quot[YW-1:0];
                    if (cnt_reg >= CW'(sws_pkg::MIN_VAR_N)) begin
                        addr_next  = start_reg;
                        issue_next = '0;
                        k_next     = '0;
                        sq_next    = '0;
                        state_next = ST_WALK2;
                    end else if (cnt_reg >= CW'(sws_pkg::MIN_SLOPE_N)) begin
                        state_next = ST_SPROD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_WALK2: begin
                if (rd_vld_reg) begin
                    prod_next   = (2*YW)'(diff) * (2*YW)'(diff);
                    sq_vld_next = 1'b1;
                end
                if (sq_vld_reg) begin
                    sq_next = sq_fin;
                    k_next  = kp1;
                    if (kp1 == cnt_reg) begin
                        dvd_next   = NW'({sq_fin + VQW'({cnt_reg, 1'b0}), 8'b0});
                        dvs_next   = DW'(cnt_reg);
                        go_next    = 1'b1;
                        state_next = ST_VDIV;
                    end
                end
            end
            ST_VDIV: begin
                if (div_done) begin
                    var_next   = div_quot[sws_pkg::VAR_W-1:0];
                    state_next = ST_SPROD;
                end
            end
            ST_SPROD: begin
                p1_next    = PRW'(PRW'(cnt_reg) * PRW'(sxy_reg));
                p2_next    = PRW'(PRW'(sx_reg) * PRW'(sum_reg));
                p3_next    = DNW'(DNW'(cnt_reg) * DNW'(sxx_reg));
                p4_next    = DNW'(DNW'(sx_reg) * DNW'(sx_reg));
                state_next = ST_SDIFF;
            end
            ST_SDIFF: begin
                neg_next   = num[PRW];
                dvd_next   = NW'({mag, 8'b0});
                dvs_next   = DW'(den);
                go_next    = 1'b1;
                state_next = ST_SDIV;
            end
            ST_SDIV: begin
                if (div_done) begin
                    slope_next = neg_reg ? neg_quot[SLW-1:0] : div_quot[SLW-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            wp_reg     <= '0;
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            go_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            wp_reg     <= wp_next;
            rd_vld_reg <= rd_vld_next;
            sq_vld_reg <= sq_vld_next;
            go_reg     <= go_next;
        end
        start_reg  <= start_next;
        addr_reg   <= addr_next;
        issue_reg  <= issue_next;
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        sx_reg     <= sx_next;
        sxx_reg    <= sxx_next;
        sxy_reg    <= sxy_next;
        prod_reg   <= prod_next;
        sq_reg     <= sq_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        p4_reg     <= p4_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        newest_reg <= newest_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
        slope_reg  <= slope_next;
    end

    assign m_valid       = (state_reg == ST_OUT);
    assign m_count       = cnt_reg;
    assign m_full_res    = (cnt_reg == CW'(WINDOW_DEPTH));
    assign m_newest      = newest_reg;
    assign m_mean        = mean_reg;
    assign m_variance_q8 = var_reg;
    assign m_slope_q8    = $signed(slope_reg);

endmodule

// ===== src/sws_checker.sv =====
// Port-level checks of the sliding window statistics block, with its bind.
module sws_checker #(
    parameter int WINDOW_DEPTH = sws_pkg::DEPTH_DEFAULT
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [$clog2(WINDOW_DEPTH+1)-1:0]   m_count,
    input logic                                m_full_res,
    input logic [sws_pkg::VAR_W-1:0]           m_variance_q8,
    input logic signed [sws_pkg::SLOPE_W-1:0]  m_slope_q8
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_count))
        else $error("result count changed while stalled");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_full_res == (m_count == CW'(WINDOW_DEPTH))))
        else $error("full flag disagrees with count");

    a_var_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_count < CW'(sws_pkg::MIN_VAR_N))
            |-> (m_variance_q8 == sws_pkg::VAR_FALLBACK))
        else $error("variance not at fallback for short window");

    a_slope_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_count < CW'(sws_pkg::MIN_SLOPE_N)) |-> (m_slope_q8 == '0))
        else $error("slope not zero for short window");

endmodule

bind sliding_window_sample_statistics sws_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
) u_sws_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_count      (m_count),
    .m_full_res   (m_full_res),
    .m_variance_q8(m_variance_q8),
    .m_slope_q8   (m_slope_q8)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window sample statistics block.
module testbench;

    localparam int DEPTH = sws_pkg::DEPTH_DEFAULT;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [CW-1:0]                      count;
        logic                               full_res;
        logic [sws_pkg::SAMPLE_W-1:0]       newest;
        logic [sws_pkg::SAMPLE_W-1:0]       mean;
        logic [sws_pkg::VAR_W-1:0]          variance_q8;
        logic signed [sws_pkg::SLOPE_W-1:0] slope_q8;
    } stats_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_kind;
    logic [sws_pkg::SAMPLE_W-1:0] s_sample;
    logic m_valid;
    logic m_ready;
    logic [CW-1:0] m_count;
    logic m_full_res;
    logic [sws_pkg::SAMPLE_W-1:0] m_newest;
    logic [sws_pkg::SAMPLE_W-1:0] m_mean;
    logic [sws_pkg::VAR_W-1:0] m_variance_q8;
    logic signed [sws_pkg::SLOPE_W-1:0] m_slope_q8;

    // Predictor state: ring of held samples, fill level and write slot.
    logic [sws_pkg::SAMPLE_W-1:0] ring [DEPTH];
    int unsigned ring_fill;
    int unsigned ring_wr;

    stats_t pending_stats [$];
    int     mismatches;
    bit     quiet_sink;   // when set, the sink never stalls

    sliding_window_sample_statistics #(.WINDOW_DEPTH(DEPTH)) u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Safety net: end a hung run with a failure, leaving plenty of margin.
    initial begin
        #(64'd20 * 64'd3_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sample at age position k, 0 being the oldest held sample.
    function automatic longint unsigned aged(int unsigned k);
        return ring[(ring_wr + DEPTH - ring_fill + k) % DEPTH];
    endfunction

    // Advance the predictor by one request and return the statistics it yields.
    function automatic stats_t window_stats(sws_pkg::op_t op,
                                            logic [sws_pkg::SAMPLE_W-1:0] smp);
        stats_t r;
        longint unsigned n, sum, mu, sq, d, y;
        longint sx, sxx, sxy, sy, num, den, x;
        if (op == sws_pkg::OP_CLEAR) begin
            ring_fill = 0;
            ring_wr   = 0;
        end else begin
            ring[ring_wr] = smp;
            ring_wr = (ring_wr + 1) % DEPTH;
            if (ring_fill < DEPTH) ring_fill++;
        end
        n = ring_fill;
        r = '0;
        r.count       = CW'(n);
        r.full_res    = (n == DEPTH);
        r.variance_q8 = sws_pkg::VAR_FALLBACK;
        sum = 0;
        mu  = 0;
        if (n > 0) begin
            r.newest = ring[(ring_wr + DEPTH - 1) % DEPTH];
            for (int unsigned k = 0; k < n; k++) sum += aged(k);
            mu = (sum + (n >> 1)) / n;
            r.mean = sws_pkg::SAMPLE_W'(mu);
        end
        if (n >= sws_pkg::MIN_VAR_N) begin
            sq = 0;
            for (int unsigned k = 0; k < n; k++) begin
                y = aged(k);
                d = (y >= mu) ? y - mu : mu - y;
                sq += d * d;
            end
            sq += 2 * n;
            r.variance_q8 = sws_pkg::VAR_W'((sq * 256) / n);
        end
        if (n >= sws_pkg::MIN_SLOPE_N) begin
            sx = 0; sxx = 0; sxy = 0; sy = 0;
            for (int unsigned k = 0; k < n; k++) begin
                x = k + 1;
                sx += x;
                sxx += x * x;
                sxy += x * longint'(aged(k));
                sy += longint'(aged(k));
            end
            num = longint'(n) * sxy - sx * sy;
            den = longint'(n) * sxx - sx * sx;
            // SV signed division truncates toward zero, as required.
            if (den > 0) r.slope_q8 = sws_pkg::SLOPE_W'((num * 256) / den);
        end
        return r;
    endfunction

    // Send one request; the expectation is queued when the block accepts it.
    // Valid stays high after an accept unless the next request idles first.
    task automatic send_request(sws_pkg::op_t op, logic [sws_pkg::SAMPLE_W-1:0] smp,
                                bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < 17) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_kind   <= op;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        pending_stats.push_back(window_stats(op, smp));
    endtask

    // Sink: stall at random, check every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        stats_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_count, m_full_res, m_newest, m_mean, m_variance_q8, m_slope_q8};
                if (pending_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = pending_stats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            m_ready <= quiet_sink || ($urandom_range(99) >= 17);
        end
    end

    // Drop valid, then hold until every queued expectation has been matched.
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
    endtask

    // Extremes of the sample field, empty-window readout and the small-count cases.
    task automatic test_directed;
        send_request(sws_pkg::OP_CLEAR, 16'hFFFF, 1'b0);
        send_request(sws_pkg::OP_STORE, 16'hFFFF, 1'b0);
        send_request(sws_pkg::OP_STORE, 16'h0000, 1'b0);
        send_request(sws_pkg::OP_STORE, 16'hFFFF, 1'b0);
        send_request(sws_pkg::OP_STORE, 16'h0000, 1'b1);
        send_request(sws_pkg::OP_CLEAR, 16'h1234, 1'b1);
        send_request(sws_pkg::OP_STORE, 16'h0001, 1'b1);
        send_request(sws_pkg::OP_CLEAR, 16'h0000, 1'b1);
        send_request(sws_pkg::OP_CLEAR, 16'h0000, 1'b1);
        for (int i = 0; i < 17; i++) send_request(sws_pkg::OP_STORE, 16'(i * 4000), 1'b1);
    endtask

    // Steep falling ramp past the wrap, so the slope is strongly negative.
    task automatic test_wrap_ramp;
        send_request(sws_pkg::OP_CLEAR, '0, 1'b1);
        for (int i = 0; i < 20; i++) begin
            send_request(sws_pkg::OP_STORE, 16'(65535 - i * 3000), 1'b1);
        end
    endtask

    // Random runs of stores of random length between clears, about half past the wrap.
    task automatic test_random_runs(int total, bit may_idle);
        int sent, run;
        logic [sws_pkg::SAMPLE_W-1:0] smp;
        sent = 0;
        while (sent < total) begin
            run = ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(40, 5);
            for (int i = 0; i < run; i++) begin
                case ($urandom_range(3))
                    0: smp = 16'($urandom);
                    1: smp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: smp = 16'(32768 + $signed($urandom_range(200)) - 100);
                endcase
                send_request(sws_pkg::OP_STORE, smp, may_idle);
            end
            send_request(sws_pkg::OP_CLEAR, 16'($urandom), may_idle);
            sent += run + 1;
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = 1'b0;
        s_sample   = '0;
        quiet_sink = 1'b0;
        mismatches = 0;
        ring_fill  = 0;
        ring_wr    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_wrap_ramp();
        test_random_runs(1100, 1'b1);
        // Back-to-back stretch with no idling on either side.
        quiet_sink = 1'b1;
        test_random_runs(400, 1'b0);
        quiet_sink = 1'b0;

        drain();
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sliding_window_sample_statistics.f =====
src/sws_pkg.sv
src/sws_ram.sv
src/sws_div.sv
src/sws_front.sv
src/sws_back.sv
src/sliding_window_sample_statistics.sv
src/sws_checker.sv
tb/sv/testbench.sv
